FILE: rtl/iqp_pkg.sv
// Shared constants, types and helpers for the incremental goal pose unit.
package iqp_pkg;

  localparam int unsigned KEY_W  = 12;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned QUAT_W = 16;
  localparam int unsigned STEP_W = 21;
  localparam int unsigned TRIG_W = 16;

  // Key bit positions
  localparam int unsigned KEY_NEG_PITCH = 0;
  localparam int unsigned KEY_POS_PITCH = 1;
  localparam int unsigned KEY_NEG_YAW   = 2;
  localparam int unsigned KEY_POS_YAW   = 3;
  localparam int unsigned KEY_NEG_ROLL  = 4;
  localparam int unsigned KEY_POS_ROLL  = 5;
  localparam int unsigned KEY_POS_X     = 6;
  localparam int unsigned KEY_NEG_X     = 7;
  localparam int unsigned KEY_POS_Y     = 8;
  localparam int unsigned KEY_NEG_Y     = 9;
  localparam int unsigned KEY_POS_Z     = 10;
  localparam int unsigned KEY_NEG_Z     = 11;

  // Register reset values
  localparam logic [STEP_W-1:0]        LINEAR_STEP_RST = 21'd6554;
  localparam logic signed [TRIG_W-1:0] HALF_COS_RST    = 16'sd14378;
  localparam logic signed [TRIG_W-1:0] HALF_SIN_RST    = 16'sd7855;

  typedef enum logic [1:0] {
    CFG_LINEAR_STEP = 2'd0,
    CFG_HALF_COS    = 2'd1,
    CFG_HALF_SIN    = 2'd2
  } cfg_idx_t;

  // Axis direction: -1, 0 or +1
  typedef logic signed [1:0] axis_t;

  function automatic axis_t axis_sign(input logic plus_k, input logic minus_k);
    return axis_t'({1'b0, plus_k}) - axis_t'({1'b0, minus_k});
  endfunction

endpackage

FILE: rtl/iqp_pos_path.sv
// Position path: rotate the body-frame step by the quaternion and add it.
module iqp_pos_path (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic [iqp_pkg::STEP_W-1:0]           step,
  input  logic [iqp_pkg::KEY_W-1:0]            keys,
  input  logic signed [iqp_pkg::POS_W-1:0]     pos_x,
  input  logic signed [iqp_pkg::POS_W-1:0]     pos_y,
  input  logic signed [iqp_pkg::POS_W-1:0]     pos_z,
  input  logic signed [iqp_pkg::QUAT_W-1:0]    quat_x,
  input  logic signed [iqp_pkg::QUAT_W-1:0]    quat_y,
  input  logic signed [iqp_pkg::QUAT_W-1:0]    quat_z,
  input  logic signed [iqp_pkg::QUAT_W-1:0]    quat_w,
  output logic signed [iqp_pkg::POS_W-1:0]     goal_x,
  output logic signed [iqp_pkg::POS_W-1:0]     goal_y,
  output logic signed [iqp_pkg::POS_W-1:0]     goal_z
);
  import iqp_pkg::*;

  localparam logic signed [33:0] M_ONE   = 34'sd268435456;
  localparam logic signed [57:0] RND_28  = 58'sd134217728;
  localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
  localparam logic signed [33:0] POS_MIN = -34'sd2147483648;

  // Stage 1: quaternion pair products, axis decode
  logic signed [31:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, xw_r, yw_r, zw_r;
  axis_t              ax1_r [0:2];
  logic signed [POS_W-1:0] p1_r [0:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      xx_r <= quat_x * quat_x;
      yy_r <= quat_y * quat_y;
      zz_r <= quat_z * quat_z;
      xy_r <= quat_x * quat_y;
      xz_r <= quat_x * quat_z;
      yz_r <= quat_y * quat_z;
      xw_r <= quat_x * quat_w;
      yw_r <= quat_y * quat_w;
      zw_r <= quat_z * quat_w;
      ax1_r[0] <= axis_sign(keys[KEY_POS_X], keys[KEY_NEG_X]);
      ax1_r[1] <= axis_sign(keys[KEY_POS_Y], keys[KEY_NEG_Y]);
      ax1_r[2] <= axis_sign(keys[KEY_POS_Z], keys[KEY_NEG_Z]);
      p1_r[0]  <= pos_x;
      p1_r[1]  <= pos_y;
      p1_r[2]  <= pos_z;
    end
  end

  // Stage 2: rotation matrix, Q6.28
  logic signed [33:0] m_r [0:8];
  axis_t              ax2_r [0:2];
  logic signed [POS_W-1:0] p2_r [0:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0] <= M_ONE - ((34'(yy_r) + 34'(zz_r)) <<< 1);
      m_r[1] <= (34'(xy_r) - 34'(zw_r)) <<< 1;
      m_r[2] <= (34'(xz_r) + 34'(yw_r)) <<< 1;
      m_r[3] <= (34'(xy_r) + 34'(zw_r)) <<< 1;
      m_r[4] <= M_ONE - ((34'(xx_r) + 34'(zz_r)) <<< 1);
      m_r[5] <= (34'(yz_r) - 34'(xw_r)) <<< 1;
      m_r[6] <= (34'(xz_r) - 34'(yw_r)) <<< 1;
      m_r[7] <= (34'(yz_r) + 34'(xw_r)) <<< 1;
      m_r[8] <= M_ONE - ((34'(xx_r) + 34'(yy_r)) <<< 1);
      ax2_r  <= ax1_r;
      p2_r   <= p1_r;
    end
  end

  // Stage 3: step times matrix entry, signed by the column's axis
  logic signed [55:0] pr_nxt [0:8];
  logic signed [55:0] pr_r   [0:8];
  logic signed [POS_W-1:0] p3_r [0:2];

  always_comb begin
    logic signed [55:0] mag;
    for (int k = 0; k < 9; k++) begin
      mag = 56'($signed({1'b0, step})) * 56'(m_r[k]);
      case (ax2_r[k % 3])
        2'sd1:   pr_nxt[k] = mag;
        -2'sd1:  pr_nxt[k] = -mag;
        default: pr_nxt[k] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_r <= pr_nxt;
      p3_r <= p2_r;
    end
  end

  // Stage 4: row sums, rounded to Q14.16
  logic signed [29:0] d_nxt [0:2];
  logic signed [29:0] d_r   [0:2];
  logic signed [POS_W-1:0] p4_r [0:2];

  always_comb begin
    logic signed [57:0] sum;
    for (int r = 0; r < 3; r++) begin
      sum = 58'(pr_r[3*r]) + 58'(pr_r[3*r+1]) + 58'(pr_r[3*r+2]) + RND_28;
      d_nxt[r] = sum[57:28];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r  <= d_nxt;
      p4_r <= p3_r;
    end
  end

  // Stage 5: add to position, saturate
  logic signed [POS_W-1:0] g_nxt [0:2];
  logic signed [POS_W-1:0] g_r   [0:2];

  always_comb begin
    logic signed [33:0] t;
    for (int r = 0; r < 3; r++) begin
      t = 34'(p4_r[r]) + 34'(d_r[r]);
      if (t > POS_MAX)      g_nxt[r] = POS_MAX[POS_W-1:0];
      else if (t < POS_MIN) g_nxt[r] = POS_MIN[POS_W-1:0];
      else                  g_nxt[r] = t[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r <= g_nxt;
    end
  end

  assign goal_x = g_r[0];
  assign goal_y = g_r[1];
  assign goal_z = g_r[2];

endmodule

FILE: rtl/iqp_quat_path.sv
// Orientation path: build the increment quaternion and multiply it in.
module iqp_quat_path (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic signed [iqp_pkg::TRIG_W-1:0]    half_cos,
  input  logic signed [iqp_pkg::TRIG_W-1:0]    half_sin,
  input  logic [iqp_pkg::KEY_W-1:0]            keys,
  input  logic signed [iqp_pkg::QUAT_W-1:0]    quat_x,
  input  logic signed [iqp_pkg::QUAT_W-1:0]    quat_y,
  input  logic signed [iqp_pkg::QUAT_W-1:0]    quat_z,
  input  logic signed [iqp_pkg::QUAT_W-1:0]    quat_w,
  output logic signed [iqp_pkg::QUAT_W-1:0]    goal_x,
  output logic signed [iqp_pkg::QUAT_W-1:0]    goal_y,
  output logic signed [iqp_pkg::QUAT_W-1:0]    goal_z,
  output logic signed [iqp_pkg::QUAT_W-1:0]    goal_w
);
  import iqp_pkg::*;

  localparam logic signed [16:0] TRIG_ONE = 17'sd16384;
  localparam logic signed [47:0] RND_28   = 48'sd134217728;
  localparam logic signed [37:0] RND_14   = 38'sd8192;
  localparam logic signed [23:0] Q_MAX    = 24'sd32767;
  localparam logic signed [23:0] Q_MIN    = -24'sd32768;

  function automatic logic signed [16:0] cos_of(input axis_t a,
                                                input logic signed [TRIG_W-1:0] c);
    return (a != 2'sd0) ? 17'(c) : TRIG_ONE;
  endfunction

  function automatic logic signed [16:0] sin_of(input axis_t a,
                                                input logic signed [TRIG_W-1:0] s);
    logic signed [16:0] v;
    case (a)
      2'sd1:   v = 17'(s);
      -2'sd1:  v = -17'(s);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Stage 1: yaw/pitch pair products
  logic signed [16:0] cr_c, sr_c, cp_c, sp_c, cy_c, sy_c;
  logic signed [31:0] cycp_r, sysp_r, cysp_r, sycp_r;
  logic signed [16:0] cr_r, sr_r;
  logic signed [QUAT_W-1:0] q1_r [0:3];

  always_comb begin
    cr_c = cos_of(axis_sign(keys[KEY_POS_ROLL], keys[KEY_NEG_ROLL]), half_cos);
    sr_c = sin_of(axis_sign(keys[KEY_POS_ROLL], keys[KEY_NEG_ROLL]), half_sin);
    cp_c = cos_of(axis_sign(keys[KEY_POS_PITCH], keys[KEY_NEG_PITCH]), half_cos);
    sp_c = sin_of(axis_sign(keys[KEY_POS_PITCH], keys[KEY_NEG_PITCH]), half_sin);
    cy_c = cos_of(axis_sign(keys[KEY_POS_YAW], keys[KEY_NEG_YAW]), half_cos);
    sy_c = sin_of(axis_sign(keys[KEY_POS_YAW], keys[KEY_NEG_YAW]), half_sin);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cycp_r  <= 32'(cy_c) * 32'(cp_c);
      sysp_r  <= 32'(sy_c) * 32'(sp_c);
      cysp_r  <= 32'(cy_c) * 32'(sp_c);
      sycp_r  <= 32'(sy_c) * 32'(cp_c);
      cr_r    <= cr_c;
      sr_r    <= sr_c;
      q1_r[0] <= quat_x;
      q1_r[1] <= quat_y;
      q1_r[2] <= quat_z;
      q1_r[3] <= quat_w;
    end
  end

  // Stage 2: triple products with roll
  logic signed [47:0] t_r [0:7];
  logic signed [QUAT_W-1:0] q2_r [0:3];

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r[0] <= 48'(cycp_r) * 48'(cr_r);
      t_r[1] <= 48'(sysp_r) * 48'(sr_r);
      t_r[2] <= 48'(cycp_r) * 48'(sr_r);
      t_r[3] <= 48'(sysp_r) * 48'(cr_r);
      t_r[4] <= 48'(cysp_r) * 48'(cr_r);
      t_r[5] <= 48'(sycp_r) * 48'(sr_r);
      t_r[6] <= 48'(sycp_r) * 48'(cr_r);
      t_r[7] <= 48'(cysp_r) * 48'(sr_r);
      q2_r   <= q1_r;
    end
  end

  // Stage 3: increment quaternion, rounded to Q14 (w, x, y, z)
  logic signed [47:0] is_c [0:3];
  logic signed [19:0] i_r  [0:3];
  logic signed [QUAT_W-1:0] q3_r [0:3];

  always_comb begin
    is_c[0] = t_r[0] + t_r[1] + RND_28;
    is_c[1] = t_r[2] - t_r[3] + RND_28;
    is_c[2] = t_r[4] + t_r[5] + RND_28;
    is_c[3] = t_r[6] - t_r[7] + RND_28;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        i_r[k] <= is_c[k][47:28];
      end
      q3_r <= q2_r;
    end
  end

  // Stage 4: Hamilton product terms
  logic signed [35:0] wi_r, xi_r, yi_r, zi_r;   // q * i for goal w
  logic signed [35:0] ax_r, bx_r, cx_r, dx_r;   // goal x
  logic signed [35:0] ay_r, by_r, cy_r, dy_r;   // goal y
  logic signed [35:0] az_r, bz_r, cz_r, dz_r;   // goal z

  always_ff @(posedge clk) begin
    if (adv) begin
      wi_r <= 36'(q3_r[3]) * 36'(i_r[0]);
      xi_r <= 36'(q3_r[0]) * 36'(i_r[1]);
      yi_r <= 36'(q3_r[1]) * 36'(i_r[2]);
      zi_r <= 36'(q3_r[2]) * 36'(i_r[3]);
      ax_r <= 36'(q3_r[3]) * 36'(i_r[1]);
      bx_r <= 36'(q3_r[0]) * 36'(i_r[0]);
      cx_r <= 36'(q3_r[1]) * 36'(i_r[3]);
      dx_r <= 36'(q3_r[2]) * 36'(i_r[2]);
      ay_r <= 36'(q3_r[3]) * 36'(i_r[2]);
      by_r <= 36'(q3_r[0]) * 36'(i_r[3]);
      cy_r <= 36'(q3_r[1]) * 36'(i_r[0]);
      dy_r <= 36'(q3_r[2]) * 36'(i_r[1]);
      az_r <= 36'(q3_r[3]) * 36'(i_r[3]);
      bz_r <= 36'(q3_r[0]) * 36'(i_r[2]);
      cz_r <= 36'(q3_r[1]) * 36'(i_r[1]);
      dz_r <= 36'(q3_r[2]) * 36'(i_r[0]);
    end
  end

  // Stage 5: sum, round to Q14, saturate
  logic signed [37:0] s_c [0:3];
  logic signed [QUAT_W-1:0] o_nxt [0:3];
  logic signed [QUAT_W-1:0] o_r   [0:3];

  always_comb begin
    logic signed [23:0] rv;
    s_c[0] = 38'(ax_r) + 38'(bx_r) + 38'(cx_r) - 38'(dx_r) + RND_14;
    s_c[1] = 38'(ay_r) - 38'(by_r) + 38'(cy_r) + 38'(dy_r) + RND_14;
    s_c[2] = 38'(az_r) + 38'(bz_r) - 38'(cz_r) + 38'(dz_r) + RND_14;
    s_c[3] = 38'(wi_r) - 38'(xi_r) - 38'(yi_r) - 38'(zi_r) + RND_14;
    for (int k = 0; k < 4; k++) begin
      rv = s_c[k][37:14];
      if (rv > Q_MAX)      o_nxt[k] = Q_MAX[QUAT_W-1:0];
      else if (rv < Q_MIN) o_nxt[k] = Q_MIN[QUAT_W-1:0];
      else                 o_nxt[k] = rv[QUAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r <= o_nxt;
    end
  end

  assign goal_x = o_r[0];
  assign goal_y = o_r[1];
  assign goal_z = o_r[2];
  assign goal_w = o_r[3];

endmodule

FILE: rtl/incremental_goal_pose_quaternion_unit.sv
// Top level: config registers, valid pipeline and the two datapaths.
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    pressed_keys, cur_pos_*, cur_quat_*
//  out_     output     out_valid / out_stall  goal_pos_*, goal_quat_*
//  cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// Five register stages; one item is taken every cycle while the output flows.
// The stages hold the multiply levels of each path and the wide sums; the
// saturation shares the last stage with the final add or sum.
// Reset clears the valid bits and loads the register defaults.
// A stall while the output holds a valid item freezes the whole pipeline; nothing is dropped.
module incremental_goal_pose_quaternion_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [iqp_pkg::KEY_W-1:0]          in_pressed_keys,
  input  logic signed [iqp_pkg::POS_W-1:0]   in_cur_pos_x,
  input  logic signed [iqp_pkg::POS_W-1:0]   in_cur_pos_y,
  input  logic signed [iqp_pkg::POS_W-1:0]   in_cur_pos_z,
  input  logic signed [iqp_pkg::QUAT_W-1:0]  in_cur_quat_x,
  input  logic signed [iqp_pkg::QUAT_W-1:0]  in_cur_quat_y,
  input  logic signed [iqp_pkg::QUAT_W-1:0]  in_cur_quat_z,
  input  logic signed [iqp_pkg::QUAT_W-1:0]  in_cur_quat_w,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [iqp_pkg::POS_W-1:0]   out_goal_pos_x,
  output logic signed [iqp_pkg::POS_W-1:0]   out_goal_pos_y,
  output logic signed [iqp_pkg::POS_W-1:0]   out_goal_pos_z,
  output logic signed [iqp_pkg::QUAT_W-1:0]  out_goal_quat_x,
  output logic signed [iqp_pkg::QUAT_W-1:0]  out_goal_quat_y,
  output logic signed [iqp_pkg::QUAT_W-1:0]  out_goal_quat_z,
  output logic signed [iqp_pkg::QUAT_W-1:0]  out_goal_quat_w,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [iqp_pkg::STEP_W-1:0]         cfg_wdata
);
  import iqp_pkg::*;

  // Config registers
  logic [STEP_W-1:0]        linear_step_r;
  logic signed [TRIG_W-1:0] half_cos_r, half_sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linear_step_r <= LINEAR_STEP_RST;
      half_cos_r    <= HALF_COS_RST;
      half_sin_r    <= HALF_SIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LINEAR_STEP: linear_step_r <= cfg_wdata;
        CFG_HALF_COS:    half_cos_r    <= cfg_wdata[TRIG_W-1:0];
        CFG_HALF_SIN:    half_sin_r    <= cfg_wdata[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel with the stages; the pipe advances unless the output
  // holds an item that is stalled.
  logic [4:0] vld_r, vld_nxt;
  logic       adv;

  assign adv      = !(vld_r[4] && out_stall);
  assign in_stall = !adv;
  assign vld_nxt  = {vld_r[3:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[4];

  iqp_pos_path u_pos (
    .clk    (clk),
    .adv    (adv),
    .step   (linear_step_r),
    .keys   (in_pressed_keys),
    .pos_x  (in_cur_pos_x),
    .pos_y  (in_cur_pos_y),
    .pos_z  (in_cur_pos_z),
    .quat_x (in_cur_quat_x),
    .quat_y (in_cur_quat_y),
    .quat_z (in_cur_quat_z),
    .quat_w (in_cur_quat_w),
    .goal_x (out_goal_pos_x),
    .goal_y (out_goal_pos_y),
    .goal_z (out_goal_pos_z)
  );

  iqp_quat_path u_quat (
    .clk      (clk),
    .adv      (adv),
    .half_cos (half_cos_r),
    .half_sin (half_sin_r),
    .keys     (in_pressed_keys),
    .quat_x   (in_cur_quat_x),
    .quat_y   (in_cur_quat_y),
    .quat_z   (in_cur_quat_z),
    .quat_w   (in_cur_quat_w),
    .goal_x   (out_goal_quat_x),
    .goal_y   (out_goal_quat_y),
    .goal_z   (out_goal_quat_z),
    .goal_w   (out_goal_quat_w)
  );

endmodule
